FILE: rtl/fpba_pkg.sv
// Package for the fit policy block allocator.
// Holds the controller state type, operation and policy codes, and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package fpba_pkg;

  // Item operations.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Placement policies held in the fit_method register.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FIT_METHOD  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } fpba_state_t;

endpackage

FILE: rtl/fpba_mem.sv
// Block table memory: one synchronous write port and one registered read port.
// Each entry holds the used flag above the block size. Uses no package items.
`timescale 1ns / 1ps

module fpba_mem #(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(NUM_BLOCKS)-1:0] waddr,
  input  logic [SIZE_BITS:0]            wdata,
  input  logic                          re,
  input  logic [$clog2(NUM_BLOCKS)-1:0] raddr,
  output logic [SIZE_BITS:0]            rdata
);

  logic [SIZE_BITS:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fpba_scan.sv
// Allocator controller: takes items, writes loads, scans the table one entry per cycle,
// keeps the current pick and commits it. Depends on fpba_pkg and drives fpba_mem.
`timescale 1ns / 1ps

module fpba_scan
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic [$clog2(NUM_BLOCKS)-1:0]       block_index,
  input  logic [SIZE_BITS-1:0]                block_size,
  input  logic [SIZE_BITS-1:0]                request_size,
  input  logic [1:0]                          fit_method,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]     block_count,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                res_alloc,
  output logic [$clog2(NUM_BLOCKS)-1:0]       res_index,
  output logic [SIZE_BITS-1:0]                res_frag,
  output logic                                mem_we,
  output logic [$clog2(NUM_BLOCKS)-1:0]       mem_waddr,
  output logic [SIZE_BITS:0]                  mem_wdata,
  output logic                                mem_re,
  output logic [$clog2(NUM_BLOCKS)-1:0]       mem_raddr,
  input  logic [SIZE_BITS:0]                  mem_rdata
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  fpba_state_t state, state_next;

  logic [SIZE_BITS-1:0] req;
  logic [1:0]           method;
  logic [AW-1:0]        eval_idx;
  logic                 found;
  logic [AW-1:0]        pick_idx;
  logic [SIZE_BITS-1:0] pick_left;
  logic [SIZE_BITS-1:0] pick_size;

  logic [CW-1:0]        n_clamp;
  logic                 accept;
  logic                 start_scan;
  logic                 load_ok;
  logic                 rd_used;
  logic [SIZE_BITS-1:0] rd_size;
  logic [SIZE_BITS-1:0] left;
  logic                 cand;
  logic                 take;
  logic                 last;
  logic                 scan_done;
  logic                 res_fire;

  assign n_clamp = (block_count > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : block_count;
  assign accept  = in_valid && in_ready;
  assign load_ok = CW'(block_index) < CW'(NUM_BLOCKS);
  assign start_scan = accept && (operation == OP_ALLOC) && (fit_method != 2'd3)
                      && (n_clamp != '0);

  assign rd_used = mem_rdata[SIZE_BITS];
  assign rd_size = mem_rdata[SIZE_BITS-1:0];
  assign left    = rd_size - req;
  assign cand    = !rd_used && (rd_size >= req);
  assign take    = cand && (!found
                   || ((method == FIT_BEST) && (left < pick_left))
                   || ((method == FIT_WORST) && (left > pick_left)));
  assign last      = (CW'(eval_idx) + CW'(1)) == n_clamp;
  assign scan_done = (cand && (method == FIT_FIRST)) || last;
  assign res_fire  = res_valid && res_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_scan) begin
          state_next = ST_SCAN;
        end else if (accept) begin
          state_next = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory port control.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = block_index;
    mem_wdata = {1'b0, block_size};
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_we   = accept && (operation == OP_LOAD) && load_ok;
        mem_re   = start_scan;
      end
      ST_SCAN: begin
        mem_re    = !scan_done;
        mem_raddr = eval_idx + AW'(1);
      end
      ST_RESP: begin
        res_valid = 1'b1;
        mem_we    = res_fire && found;
        mem_waddr = pick_idx;
        mem_wdata = {1'b1, pick_size};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res_alloc = found;
  assign res_index = pick_idx;
  assign res_frag  = pick_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan datapath; a fresh item clears the pick so a miss reports zeros.
  always_ff @(posedge clk) begin
    if (accept) begin
      req       <= request_size;
      method    <= fit_method;
      eval_idx  <= '0;
      found     <= 1'b0;
      pick_idx  <= '0;
      pick_left <= '0;
    end else if (state == ST_SCAN) begin
      eval_idx <= eval_idx + AW'(1);
      if (take) begin
        found     <= 1'b1;
        pick_idx  <= eval_idx;
        pick_left <= left;
        pick_size <= rd_size;
      end
    end
  end

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("table read and write issued in the same cycle");

  a_scan_ends_in_resp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (state == ST_SCAN || state == ST_RESP))
    else $error("scan left without a response");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && !found) |-> (pick_idx == '0 && pick_left == '0))
    else $error("miss or load result carries nonzero fields");

endmodule

FILE: rtl/fit_policy_block_allocator.sv
// Top level of the fit policy block allocator: configuration registers and output register.
// Depends on fpba_pkg, fpba_mem and fpba_scan.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid/in_ready) carries one item per transfer. A load item
// (operation 0) writes block_size into entry block_index and marks that block free.
// An allocate item (operation 1) asks for request_size; the block picks a free entry
// among the first block_count that is large enough, by the fit_method policy (first,
// best or worst fit, ties to the lower index), marks it used and reports its index and
// the leftover fragment. Every item yields exactly one result transfer on the output
// channel (out_valid/out_ready); loads and misses report all zeros.
// Timing: a load goes from its input transfer straight to the response state. An allocate
// first scans n entries (block_count clamped to NUM_BLOCKS, or fewer when first fit stops
// at its hit); the table memory is read one entry per cycle and that single read port
// sets the rate. An unknown policy or empty table goes straight to the response state.
// The result sits in an output register, so the next item is accepted while a result
// waits; a stalled receiver holds the result and, once the next item finishes, stalls the
// controller until the register is free. Reset clears the registers to first fit and zero
// blocks and empties the pipeline; table entries must be loaded before use. Configuration
// writes (cfg_write) take effect at once; the user makes them only while idle, unenforced.

module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  cfg_write,
  input  logic                                                  cfg_index,
  input  logic [(($clog2(NUM_BLOCKS+1) > 2) ? $clog2(NUM_BLOCKS+1) : 2)-1:0] cfg_data,
  input  logic                                                  in_valid,
  output logic                                                  in_ready,
  input  logic                                                  operation,
  input  logic [$clog2(NUM_BLOCKS)-1:0]                         block_index,
  input  logic [SIZE_BITS-1:0]                                  block_size,
  input  logic [SIZE_BITS-1:0]                                  request_size,
  output logic                                                  out_valid,
  input  logic                                                  out_ready,
  output logic                                                  allocated,
  output logic [$clog2(NUM_BLOCKS)-1:0]                         granted_index,
  output logic [SIZE_BITS-1:0]                                  fragment
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  // Configuration registers.
  logic [1:0]    fit_method;
  logic [CW-1:0] block_count;

  // Controller result and memory port.
  logic                 res_valid;
  logic                 res_ready;
  logic                 res_alloc;
  logic [AW-1:0]        res_index;
  logic [SIZE_BITS-1:0] res_frag;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [SIZE_BITS:0]   mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [SIZE_BITS:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_method  <= FIT_FIRST;
      block_count <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_FIT_METHOD) begin
        fit_method <= cfg_data[1:0];
      end else if (cfg_index == CFG_BLOCK_COUNT) begin
        block_count <= cfg_data[CW-1:0];
      end
    end
  end

  fpba_mem #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fpba_scan #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .block_index  (block_index),
    .block_size   (block_size),
    .request_size (request_size),
    .fit_method   (fit_method),
    .block_count  (block_count),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_alloc    (res_alloc),
    .res_index    (res_index),
    .res_frag     (res_frag),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Output register: free when empty or when its result transfers this cycle.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      allocated     <= res_alloc;
      granted_index <= res_index;
      fragment      <= res_frag;
    end
  end

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> out_valid)
    else $error("result handed over but output register not loaded");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(res_valid && res_ready))
    else $error("pending result overwritten");

endmodule

FILE: dv/fit_policy_block_allocator_tb.sv
// Self-checking testbench for the fit policy block allocator.
// Depends on fpba_pkg and fit_policy_block_allocator from the rtl folder.
// Directed table first, then random load/allocate traffic under changing policies.
`timescale 1ns / 1ps

module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  // The policy register is two bits wide, so code 3 is reachable and must grant nothing.
  localparam logic [1:0] FIT_UNKNOWN = 2'd3;
  localparam int TABLE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SEGMENTS = 12;
  localparam int SEGMENT_ITEMS = 87;

  // One result transfer as seen on the output channel.
  typedef struct packed {
    logic        allocated;
    logic [4:0]  index;
    logic [15:0] frag;
  } grant_t;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_ALLOC,
    ROW_SET_POLICY,
    ROW_SET_COUNT
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [4:0]  idx;
    logic [15:0] value;
    bit          typed;
    grant_t      want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [4:0]  block_index;
  logic [15:0] block_size;
  logic [15:0] request_size;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        allocated;
  logic [4:0]  granted_index;
  logic [15:0] fragment;

  // Expectation attached to the item currently on the input channel. When item_typed is
  // set, the table row supplies the result and the predictor only tracks state.
  bit          item_typed;
  grant_t      item_want;

  // Predictor state: a private copy of the block table and the two registers.
  logic [15:0] size_mirror [TABLE_DEPTH];
  bit          used_mirror [TABLE_DEPTH];
  logic [1:0]  policy_copy = FIT_FIRST;
  logic [5:0]  count_copy = '0;

  grant_t      pending_grants[$];
  plan_row_t   plan[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 9;
  int          recv_idle_pct = 67;

  fit_policy_block_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .block_index  (block_index),
    .block_size   (block_size),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .allocated    (allocated),
    .granted_index(granted_index),
    .fragment     (fragment)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fit_policy_block_allocator test failed");
      $finish;
    end
  end

  // The receiver stalls at random, changing only at the falling edge. With a zero
  // percentage it never stalls.
  always @(negedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Predictor. A load stores the size and frees the block. An allocate scans the
  // first block_count entries (clamped to the table depth) for free blocks large
  // enough; first fit stops at the first hit, best fit keeps the smallest leftover and
  // worst fit the largest, and strict comparisons keep ties at the lower index. An
  // unknown policy, a miss and every load answer with all fields zero.
  function automatic grant_t predict_grant(input logic op, input logic [4:0] idx,
                                           input logic [15:0] bsize,
                                           input logic [15:0] req);
    grant_t      res;
    int          span;
    bit          found;
    bit          done;
    logic [4:0]  pick;
    logic [15:0] pick_left;
    logic [15:0] left;
    res = '0;
    found = 1'b0;
    done = 1'b0;
    pick = '0;
    pick_left = '0;
    if (op == OP_LOAD) begin
      size_mirror[idx] = bsize;
      used_mirror[idx] = 1'b0;
      return res;
    end
    if (policy_copy == FIT_UNKNOWN) begin
      return res;
    end
    span = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_copy);
    for (int j = 0; j < span; j++) begin
      if (!done && !used_mirror[j] && size_mirror[j] >= req) begin
        left = size_mirror[j] - req;
        if (!found) begin
          found = 1'b1;
          pick = j[4:0];
          pick_left = left;
          if (policy_copy == FIT_FIRST) begin
            done = 1'b1;
          end
        end else if (policy_copy == FIT_BEST && left < pick_left) begin
          pick = j[4:0];
          pick_left = left;
        end else if (policy_copy == FIT_WORST && left > pick_left) begin
          pick = j[4:0];
          pick_left = left;
        end
      end
    end
    if (found) begin
      used_mirror[pick] = 1'b1;
      res.allocated = 1'b1;
      res.index = pick;
      res.frag = pick_left;
    end
    return res;
  endfunction

  function automatic void note_mismatch(input string what, input grant_t want,
                                        input grant_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display({"%s: expected allocated=%0d index=%0d fragment=%0d, ",
                "got allocated=%0d index=%0d fragment=%0d"},
               what, want.allocated, want.index, want.frag,
               got.allocated, got.index, got.frag);
    end
  endfunction

  // Scoreboard. Everything here is sampled at the rising edge. A register write updates
  // the predictor's copy; an input transfer runs the predictor and queues the expected
  // result; an output transfer is compared with the oldest queued expectation. Pushing
  // before checking in one process keeps the order fixed within the time step.
  always @(posedge clk) begin : scoreboard
    grant_t got;
    grant_t model;
    grant_t want;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FIT_METHOD:  policy_copy = cfg_data[1:0];
          CFG_BLOCK_COUNT: count_copy = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        model = predict_grant(operation, block_index, block_size, request_size);
        pending_grants.push_back(item_typed ? item_want : model);
      end
      if (out_valid && out_ready) begin
        got = {allocated, granted_index, fragment};
        if (pending_grants.size() == 0) begin
          note_mismatch("result with no expectation waiting", '0, got);
        end else begin
          want = pending_grants.pop_front();
          if (got.allocated !== want.allocated || got.index !== want.index ||
              got.frag !== want.frag) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
    end
  end

  // Sizes lean toward small values of random magnitude so that requests fit often,
  // with zero and the maximum mixed in.
  function automatic logic [15:0] pick_size();
    int roll;
    int bits;
    roll = $urandom_range(99);
    if (roll < 5) begin
      return 16'h0000;
    end
    if (roll < 10) begin
      return 16'hFFFF;
    end
    bits = $urandom_range(16, 1);
    return 16'($urandom & ((32'd1 << bits) - 1));
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [4:0] idx,
                                  input logic [15:0] value, input bit typed,
                                  input grant_t want);
    plan_row_t row;
    row.kind = kind;
    row.idx = idx;
    row.value = value;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  // One input transfer. Called and returning at a falling edge. A sender gap lowers
  // valid before the item; otherwise valid stays high from the previous item and only
  // the payload moves on.
  task automatic send_item(input logic op, input logic [4:0] idx, input logic [15:0] bsize,
                           input logic [15:0] req, input bit typed, input grant_t want);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    operation <= op;
    block_index <= idx;
    block_size <= bsize;
    request_size <= req;
    item_typed <= typed;
    item_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Let every outstanding result arrive, then wait on with valid low so the controller is
  // back in its idle state before a register changes.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic which, input logic [5:0] data);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random load or allocate item. Most loads land inside the scanned range so that
  // used blocks come back into play; the rest hit any entry of the table.
  task automatic send_random_item(input int span);
    logic [4:0] idx;
    if ($urandom_range(99) < 40) begin
      if (span > 0 && $urandom_range(99) < 80) begin
        idx = 5'($urandom_range(span - 1));
      end else begin
        idx = 5'($urandom_range(31));
      end
      send_item(OP_LOAD, idx, pick_size(), 16'($urandom), 1'b0, '0);
    end else begin
      send_item(OP_ALLOC, 5'($urandom), 16'($urandom),
                pick_size() >> $urandom_range(3), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [1:0] seg_policy [SEGMENTS];
    logic [5:0] seg_count  [SEGMENTS];
    int         span;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_FIT_METHOD;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_LOAD;
    block_index = '0;
    block_size = '0;
    request_size = '0;
    item_typed = 1'b0;
    item_want = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      used_mirror[i] = 1'b0;
      size_mirror[i] = '0;
    end

    // Directed table. Right after reset the count is zero, so an allocate must miss.
    // Only four entries are loaded here and the count stays at four, so no scan ever
    // touches an entry that was never written.
    add_row(ROW_ALLOC, 0, 16'h0000, 1'b1, '0);
    add_row(ROW_SET_COUNT, 0, 16'd4, 1'b0, '0);
    add_row(ROW_LOAD, 0, 16'hFFFF, 1'b1, '0);
    add_row(ROW_LOAD, 1, 16'h0000, 1'b1, '0);
    add_row(ROW_LOAD, 2, 16'd100, 1'b1, '0);
    add_row(ROW_LOAD, 3, 16'd50, 1'b1, '0);
    // First fit: a zero request takes any free block, even one of size zero.
    add_row(ROW_ALLOC, 0, 16'h0000, 1'b1, '{1'b1, 5'd0, 16'hFFFF});
    add_row(ROW_ALLOC, 0, 16'h0000, 1'b1, '{1'b1, 5'd1, 16'h0000});
    add_row(ROW_ALLOC, 0, 16'd60, 1'b0, '0);
    add_row(ROW_ALLOC, 0, 16'd1, 1'b0, '0);
    // Every block is used now, so nothing fits.
    add_row(ROW_ALLOC, 0, 16'h0000, 1'b1, '0);
    add_row(ROW_LOAD, 0, 16'hFFFF, 1'b1, '0);
    add_row(ROW_LOAD, 1, 16'h0000, 1'b1, '0);
    add_row(ROW_LOAD, 2, 16'd100, 1'b1, '0);
    add_row(ROW_LOAD, 3, 16'd50, 1'b1, '0);
    // Best fit walks down the leftovers; the largest request fits only block 0.
    add_row(ROW_SET_POLICY, 0, 16'(FIT_BEST), 1'b0, '0);
    add_row(ROW_ALLOC, 0, 16'd40, 1'b0, '0);
    add_row(ROW_ALLOC, 0, 16'd40, 1'b0, '0);
    add_row(ROW_ALLOC, 0, 16'hFFFF, 1'b1, '{1'b1, 5'd0, 16'h0000});
    add_row(ROW_ALLOC, 0, 16'd1, 1'b0, '0);
    // Worst fit, then a tie between two equal blocks that must go to the lower index.
    add_row(ROW_SET_POLICY, 0, 16'(FIT_WORST), 1'b0, '0);
    add_row(ROW_LOAD, 0, 16'hFFFF, 1'b1, '0);
    add_row(ROW_LOAD, 2, 16'd50, 1'b1, '0);
    add_row(ROW_LOAD, 3, 16'd50, 1'b1, '0);
    add_row(ROW_ALLOC, 0, 16'h0000, 1'b1, '{1'b1, 5'd0, 16'hFFFF});
    add_row(ROW_ALLOC, 0, 16'd10, 1'b0, '0);
    // The unused policy code grants nothing.
    add_row(ROW_SET_POLICY, 0, 16'(FIT_UNKNOWN), 1'b0, '0);
    add_row(ROW_ALLOC, 0, 16'h0000, 1'b1, '0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_LOAD: begin
          send_item(OP_LOAD, plan[i].idx, plan[i].value, 16'($urandom),
                    plan[i].typed, plan[i].want);
        end
        ROW_ALLOC: begin
          send_item(OP_ALLOC, 5'($urandom), 16'($urandom), plan[i].value,
                    plan[i].typed, plan[i].want);
        end
        ROW_SET_POLICY: write_reg(CFG_FIT_METHOD, plan[i].value[5:0]);
        ROW_SET_COUNT:  write_reg(CFG_BLOCK_COUNT, plan[i].value[5:0]);
        default: ;
      endcase
    end

    // Fill the whole table so that any count, including values past the depth, only
    // ever scans written entries.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_item(OP_LOAD, 5'(i), pick_size(), 16'($urandom), 1'b0, '0);
    end

    // Register settings per segment, with the extremes of both registers among them.
    seg_policy = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNKNOWN, FIT_BEST, FIT_FIRST,
                   FIT_WORST, FIT_BEST, FIT_FIRST, FIT_WORST, FIT_BEST, FIT_WORST};
    seg_count  = '{6'd32, 6'd63, 6'd0, 6'd32, 6'd17, 6'd1, 6'd33, 6'd5, 6'd63, 6'd31,
                   6'd2, 6'd32};

    for (int s = 0; s < SEGMENTS; s++) begin
      // Sender idles lightly with a slow receiver, then the reverse, then no idling.
      if (s < 4) begin
        send_idle_pct = 9;
        recv_idle_pct = 67;
      end else if (s < 8) begin
        send_idle_pct = 67;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_FIT_METHOD, {4'b0000, seg_policy[s]});
      write_reg(CFG_BLOCK_COUNT, seg_count[s]);
      span = (seg_count[s] > TABLE_DEPTH) ? TABLE_DEPTH : int'(seg_count[s]);
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        send_random_item(span);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fit_policy_block_allocator test passed");
    end else begin
      $display("fit_policy_block_allocator test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fpba_pkg.sv
rtl/fpba_mem.sv
rtl/fpba_scan.sv
rtl/fit_policy_block_allocator.sv
dv/fit_policy_block_allocator_tb.sv
